FILE: rtl/core/ptbp_pkg.sv
// Shared constants and types for the pixel threshold bit packer.
package ptbp_pkg;

	// Row length in output bytes is padded up to a multiple of this.
	localparam int ROW_ALIGN_BYTES = 4;
	// Width of the row byte counter and of the pad count.
	localparam int MOD_W = (ROW_ALIGN_BYTES > 1) ? $clog2(ROW_ALIGN_BYTES) : 1;

	localparam int CHAN_W  = 8;
	localparam int SUM_W   = 10;
	localparam int COL_W   = 16;
	localparam int BYTE_W  = 8;
	localparam int POS_W   = 3;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [BYTE_W-1:0] BYTE_ONES = 8'hFF;
	localparam logic [POS_W-1:0]  POS_FIRST = 3'd7;
	localparam logic [POS_W-1:0]  POS_LAST  = 3'd0;

	localparam logic [COL_W-1:0]  ROW_WIDTH_RST = 16'd1;
	localparam logic [CHAN_W-1:0] THRESH_RST    = 8'd127;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROW_WIDTH      = 1'b0,
		REG_DARK_THRESHOLD = 1'b1
	} cfg_reg_t;

	// Results still owed for one pixel.
	typedef struct packed {
		logic              data_pend;
		logic [BYTE_W-1:0] data_byte;
		logic              row_done;
		logic [MOD_W-1:0]  pad_cnt;
	} job_t;

endpackage

FILE: rtl/core/pixel_threshold_bit_packer_top.sv
// Top level of the pixel threshold bit packer: binarise, pack 1bpp, pad rows.
//
//  Channel   Direction  Payload                                    Handshake
//  s_axis    in         tdata[23:0] = chan_a, chan_b, chan_c       tvalid/tready
//  m_axis    out        tdata[7:0] = packed_byte, tuser = row_end,  tvalid/tready
//                       tlast = last_of_run
//  cfg       in         cfg_index, cfg_data (row_width, threshold) cfg_valid/cfg_ready
//
// A pixel passes an input register (_s1), then one step of logic thresholds it,
// packs its bit and works out what it owes: at most one data byte and, at a row
// end, up to ROW_ALIGN_BYTES-1 pad bytes. These sit in the result register (_s2),
// which gives out one byte a cycle while m_axis is ready. Sustained rate is then one
// pixel a cycle; the single output port holds the input while row-end pads go out.
// arst_n clears all control state and loads the register reset values.
// A stall on m_axis holds the result register and then the input register.
module pixel_threshold_bit_packer_top
	import ptbp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// Pixel stream
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [23:0]           s_axis_tdata,   // [7:0] chan_a, [15:8] chan_b, [23:16] chan_c
	// Packed byte stream
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [7:0]            m_axis_tdata,   // [7:0] packed_byte
	output logic                  m_axis_tuser,   // [0] row_end
	output logic                  m_axis_tlast,   // last_of_run
	// Configuration writes
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// Configuration registers
	logic [COL_W-1:0]  row_width_q;
	logic [CHAN_W-1:0] thresh_q;

	// Packing state
	logic [BYTE_W-1:0] bit_accum_q;
	logic [POS_W-1:0]  bit_pos_q;
	logic [COL_W-1:0]  column_q;
	logic [MOD_W-1:0]  row_mod_q;

	// Input register
	logic              valid_s1;
	logic [CHAN_W-1:0] chan_a_s1, chan_b_s1, chan_c_s1;

	// Result register
	logic job_valid_s2;
	job_t job_s2;

	// Combinational pixel work
	logic [SUM_W-1:0]  sum;
	logic [SUM_W-1:0]  limit;
	logic              pix_bit;
	logic [BYTE_W-1:0] acc_new;
	logic [COL_W-1:0]  col_next;
	logic              row_done;
	logic              data_valid;
	logic [MOD_W-1:0]  mod_after;
	logic [MOD_W-1:0]  pads;
	job_t              job_next;

	logic out_last;
	logic out_fire;
	logic job_done;
	logic advance_s1;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q <= ROW_WIDTH_RST;
			thresh_q    <= THRESH_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_ROW_WIDTH:      row_width_q <= cfg_data;
				REG_DARK_THRESHOLD: thresh_q    <= cfg_data[CHAN_W-1:0];
				default: ;
			endcase
		end
	end

	// avg = sum / 3 exceeds thr exactly when sum exceeds 3*thr + 2
	always_comb begin
		sum   = SUM_W'(chan_a_s1) + SUM_W'(chan_b_s1) + SUM_W'(chan_c_s1);
		limit = SUM_W'(thresh_q) + (SUM_W'(thresh_q) << 1) + SUM_W'(2);
		pix_bit = (sum > limit);

		acc_new = bit_accum_q;
		if (!pix_bit) begin
			acc_new = bit_accum_q & ~(BYTE_W'(1) << bit_pos_q);
		end

		col_next = column_q + COL_W'(1);
		row_done = (col_next == row_width_q);

		// A full byte at a row end is also the flush byte, so at most one data byte
		data_valid = (bit_pos_q == POS_LAST) || row_done;

		if (data_valid && (row_mod_q == MOD_W'(ROW_ALIGN_BYTES - 1))) begin
			mod_after = '0;
		end else begin
			mod_after = row_mod_q + MOD_W'(data_valid);
		end

		if (row_done && (mod_after != '0)) begin
			pads = MOD_W'(ROW_ALIGN_BYTES) - mod_after;
		end else begin
			pads = '0;
		end

		job_next.data_pend = data_valid;
		job_next.data_byte = acc_new;
		job_next.row_done  = row_done;
		job_next.pad_cnt   = pads;
	end

	// Output side: data byte first, then the pad bytes
	always_comb begin
		if (job_s2.data_pend) begin
			m_axis_tdata = job_s2.data_byte;
			out_last     = (job_s2.pad_cnt == '0);
		end else begin
			m_axis_tdata = BYTE_ONES;
			out_last     = (job_s2.pad_cnt == MOD_W'(1));
		end
	end

	assign m_axis_tvalid = job_valid_s2;
	assign m_axis_tlast  = out_last;
	assign m_axis_tuser  = job_s2.row_done && out_last;

	assign out_fire   = m_axis_tvalid && m_axis_tready;
	assign job_done   = out_fire && out_last;
	assign advance_s1 = valid_s1 && (!job_valid_s2 || job_done);
	assign s_axis_tready = !valid_s1 || advance_s1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			chan_a_s1 <= s_axis_tdata[7:0];
			chan_b_s1 <= s_axis_tdata[15:8];
			chan_c_s1 <= s_axis_tdata[23:16];
		end
	end

	// Packing state advances as each pixel moves into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_accum_q <= BYTE_ONES;
			bit_pos_q   <= POS_FIRST;
			column_q    <= '0;
			row_mod_q   <= '0;
		end else if (advance_s1) begin
			bit_accum_q <= data_valid ? BYTE_ONES : acc_new;
			bit_pos_q   <= data_valid ? POS_FIRST : bit_pos_q - POS_W'(1);
			column_q    <= row_done ? '0 : col_next;
			row_mod_q   <= row_done ? '0 : mod_after;
		end
	end

	// Result register: load a new job, or drop one byte per transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_s2 <= 1'b0;
			job_s2       <= '0;
		end else if (advance_s1) begin
			job_valid_s2 <= data_valid || (pads != '0);
			job_s2       <= job_next;
		end else if (out_fire) begin
			if (out_last) begin
				job_valid_s2 <= 1'b0;
			end
			if (job_s2.data_pend) begin
				job_s2.data_pend <= 1'b0;
			end else begin
				job_s2.pad_cnt <= job_s2.pad_cnt - MOD_W'(1);
			end
		end
	end

	// A valid result always owes at least one byte
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (job_s2.data_pend || (job_s2.pad_cnt != '0)))
		else $error("result register valid with nothing owed");

	// Pad bytes only ever follow a row end
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !job_s2.data_pend) |-> job_s2.row_done)
		else $error("pad byte outside a row end");

	// The byte under construction is all ones whenever no bit has been packed
	assert property (@(posedge clk) disable iff (!arst_n)
		(bit_pos_q == POS_FIRST) |-> (bit_accum_q == BYTE_ONES))
		else $error("fresh byte not all ones");

	// After a row-end pixel enters the result register, the row byte count is back to zero
	assert property (@(posedge clk) disable iff (!arst_n)
		(advance_s1 && row_done) |=> (row_mod_q == '0))
		else $error("row byte count not aligned after row end");

endmodule
